>>> design/gbw_pkg.sv
// Shared types, register indexes and kernel constants for the window filter.
package gbw_pkg;

  localparam int DIM_W      = 14;   // holds a clamped frame width
  localparam int ROW_W      = 13;   // input row counter and clamped height
  localparam int OUT_ROW_W  = 12;   // output row counter
  localparam int MIN_DIM    = 5;
  localparam int MAX_HEIGHT = 4096;

  localparam logic [1:0] REG_MODE   = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  // Gaussian numerators over 1e6, row-major 5x5
  localparam int unsigned GAUSS_NUM [25] = '{
    3663, 14652, 25641, 14652, 3663,
    14652, 58608, 95238, 58608, 14652,
    25641, 95238, 146520, 95238, 25641,
    14652, 58608, 95238, 58608, 14652,
    3663, 14652, 25641, 14652, 3663
  };
  localparam int unsigned BOX_NUM = 111110;

  // Round-half-up of num/1e6 in Q0.frac
  function automatic longint unsigned qweight(input longint unsigned num, input int frac);
    return ((num << frac) + 64'd500000) / 64'd1000000;
  endfunction

  // Window masks that travel with an item
  typedef struct packed {
    logic [4:0] rmask;
    logic       box;
  } gbw_mask_t;

  typedef struct packed {
    logic [7:0] ch2;
    logic [7:0] ch1;
    logic [7:0] ch0;
    logic       last;
  } gbw_word_t;

endpackage

>>> design/gbw_ram.sv
// Generic single-write, single-read RAM with registered read-first output.
module gbw_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> design/gbw_cell.sv
// One window column: holds five pixels, passes them left, forms its weighted column sum.
module gbw_cell #(
  parameter int COL  = 0,
  parameter int NCH  = 3,
  parameter int FRAC = 16
) (
  input  logic                             clk,
  input  logic                             shift,
  input  logic [4:0][8*NCH-1:0]            col_in,
  output logic [4:0][8*NCH-1:0]            col_out,
  input  logic                             cmask,
  input  gbw_pkg::gbw_mask_t               ctl,
  output logic [NCH-1:0][FRAC+8:0]         sum
);

  localparam int WW = FRAC - 2;
  localparam int AW = FRAC + 9;
  localparam logic [WW-1:0] BW = WW'(gbw_pkg::qweight(gbw_pkg::BOX_NUM, FRAC));

  logic [4:0][8*NCH-1:0]  col;
  logic [WW-1:0]          gw [5];
  logic [4:0][WW-1:0]     wt_sel;
  logic [4:0]             keep;
  logic [NCH-1:0][AW-1:0] sum_next;

  for (genvar i = 0; i < 5; i++) begin : g_wt
    assign gw[i] = WW'(gbw_pkg::qweight(gbw_pkg::GAUSS_NUM[i*5+COL], FRAC));
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      col <= col_in;
    end
    sum <= sum_next;
  end

  assign col_out = col;

  always_comb begin
    for (int i = 0; i < 5; i++) begin
      wt_sel[i] = ctl.box ? BW : gw[i];
      // drop taps outside the frame and outside the box kernel
      keep[i] = ctl.rmask[i] && cmask && (!ctl.box || (i >= 2 && COL >= 2));
    end
  end

  always_comb begin
    sum_next = '0;
    for (int c = 0; c < NCH; c++) begin
      for (int i = 0; i < 5; i++) begin
        sum_next[c] = sum_next[c] + AW'(wt_sel[i]) *
                      (keep[i] ? AW'(col[i][8*c +: 8]) : AW'(0));
      end
    end
  end

endmodule

>>> design/gaussian_box_window_filter.sv
// Top level: line buffers, a five-cell window chain, final adder and output queue.
//
//  channel | signals                                   | moves
//  cfg     | cfg_write, cfg_index, cfg_data            | register write, no wait
//  in      | in_valid, in_stall, req_type, pixel_ch0-2 | one pixel or drain word
//  out     | out_valid, out_stall, out_ch0-2, frame_last | one filtered word
//
// One input word per cycle while in_stall is low; a result passes the line-data, window and
// column-sum registers into the queue after the input word that completes its window. Four
// line-buffer RAMs are read once per word at in_column; the row slot's RAM is written.
// Synchronous reset resets counters, config, valid flags and the queue; no clearing pass. An
// 8-entry queue absorbs out_stall; in_stall rises when queued plus in-flight results reach 8.
module gaussian_box_window_filter #(
  parameter int MAX_WIDTH      = 2048,
  parameter int CHANNELS       = 3,
  parameter int COEF_FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        req_type,
  input  logic [7:0]  pixel_ch0,
  input  logic [7:0]  pixel_ch1,
  input  logic [7:0]  pixel_ch2,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_ch0,
  output logic [7:0]  out_ch1,
  output logic [7:0]  out_ch2,
  output logic        frame_last
);

  localparam int NCH   = (CHANNELS < 3) ? CHANNELS : 3;
  localparam int PW    = 8 * NCH;
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int AW    = COEF_FRAC_BITS + 9;
  localparam int TW    = AW + 3;
  localparam int DW    = gbw_pkg::DIM_W;
  localparam int RW    = gbw_pkg::ROW_W;
  localparam int ORW   = gbw_pkg::OUT_ROW_W;
  localparam int QDEPTH = 8;
  localparam int QPW   = $clog2(QDEPTH);

  // configuration registers
  logic        filter_mode;
  logic [11:0] frame_width;
  logic [12:0] frame_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_mode  <= 1'b0;
      frame_width  <= 12'd512;
      frame_height <= 13'd512;
    end else if (cfg_write) begin
      unique case (cfg_index)
        gbw_pkg::REG_MODE:   filter_mode  <= cfg_data[0];
        gbw_pkg::REG_WIDTH:  frame_width  <= cfg_data[11:0];
        gbw_pkg::REG_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // counters
  logic [CW-1:0]  in_column;
  logic [RW-1:0]  in_row;
  logic [CW-1:0]  out_column;
  logic [ORW-1:0] out_row;

  logic [DW-1:0]  w;
  logic [RW-1:0]  h;
  logic [1:0]     r;
  logic [DW-1:0]  in_col_ext;
  logic [DW-1:0]  out_col_ext;
  logic           accept, act, emit, col_wrap, out_last, data_ok;
  logic [2:0][7:0] px_in;
  logic [PW-1:0]  pix;
  gbw_pkg::gbw_mask_t msk;
  logic [4:0]     cmask;

  always_comb begin
    if (DW'(frame_width) < DW'(gbw_pkg::MIN_DIM)) begin
      w = DW'(gbw_pkg::MIN_DIM);
    end else if (DW'(frame_width) > DW'(MAX_WIDTH)) begin
      w = DW'(MAX_WIDTH);
    end else begin
      w = DW'(frame_width);
    end
    if (frame_height < RW'(gbw_pkg::MIN_DIM)) begin
      h = RW'(gbw_pkg::MIN_DIM);
    end else if (frame_height > RW'(gbw_pkg::MAX_HEIGHT)) begin
      h = RW'(gbw_pkg::MAX_HEIGHT);
    end else begin
      h = frame_height;
    end
  end

  assign r           = filter_mode ? 2'd1 : 2'd2;
  assign in_col_ext  = DW'(in_column);
  assign out_col_ext = DW'(out_column);
  assign accept      = in_valid && !in_stall;
  // a drain word at the frame origin does nothing
  assign act      = accept && !(req_type && in_row == '0 && in_column == '0);
  assign emit     = (in_row > RW'(r)) || (in_row == RW'(r) && in_col_ext >= DW'(r));
  assign col_wrap = (in_col_ext + DW'(1)) >= w;
  assign out_last = (RW'(out_row) + RW'(1) >= h) && (out_col_ext + DW'(1) >= w);
  assign data_ok  = !req_type && in_row < h;
  assign px_in    = {pixel_ch2, pixel_ch1, pixel_ch0};
  assign pix      = data_ok ? px_in[NCH-1:0] : '0;

  // frame-edge masks for the window of the next result
  always_comb begin
    logic signed [15:0] rr;
    logic signed [15:0] cc;
    logic signed [15:0] ctr;
    ctr = filter_mode ? 16'sd3 : 16'sd2;
    msk.box = filter_mode;
    for (int i = 0; i < 5; i++) begin
      rr = $signed(16'(out_row)) + 16'(i) - ctr;
      cc = $signed(16'(out_column)) + 16'(i) - ctr;
      msk.rmask[i] = (rr >= 0) && (rr < $signed(16'(h)));
      cmask[i]     = (cc >= 0) && (cc < $signed(16'(w)));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_column  <= '0;
      in_row     <= '0;
      out_column <= '0;
      out_row    <= '0;
    end else if (act) begin
      if (emit && out_last) begin
        in_column  <= '0;
        in_row     <= '0;
        out_column <= '0;
        out_row    <= '0;
      end else begin
        if (col_wrap) begin
          in_column <= '0;
          in_row    <= in_row + RW'(1);
        end else begin
          in_column <= in_column + CW'(1);
        end
        if (emit) begin
          if (out_col_ext + DW'(1) >= w) begin
            out_column <= '0;
            out_row    <= out_row + ORW'(1);
          end else begin
            out_column <= out_column + CW'(1);
          end
        end
      end
    end
  end

  // line buffers, one per row slot
  logic [PW-1:0] rd [4];

  for (genvar k = 0; k < 4; k++) begin : g_line
    gbw_ram #(.WIDTH(PW), .DEPTH(MAX_WIDTH)) u_ram (
      .clk   (clk),
      .we    (act && in_row[1:0] == 2'(k)),
      .waddr (in_column),
      .wdata (pix),
      .re    (act),
      .raddr (in_column),
      .rdata (rd[k])
    );
  end

  // stage 1: line data arrives
  logic               v1, e1, last1;
  logic [1:0]         slot1;
  logic [PW-1:0]      pix1;
  gbw_pkg::gbw_mask_t msk1;
  logic [4:0]         cm1;
  logic [4:0][PW-1:0] ncol;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      e1 <= 1'b0;
    end else begin
      v1 <= act;
      e1 <= act && emit;
    end
    last1 <= out_last;
    slot1 <= in_row[1:0];
    pix1  <= pix;
    msk1  <= msk;
    cm1   <= cmask;
  end

  always_comb begin
    logic [1:0] sel;
    for (int i = 0; i < 4; i++) begin
      sel     = slot1 + 2'(i);
      ncol[i] = rd[sel];
    end
    ncol[4] = pix1;
  end

  // stage 2: window shifted, cells form column sums
  logic               e2, last2;
  gbw_pkg::gbw_mask_t msk2;
  logic [4:0]         cm2;
  logic [4:0][PW-1:0] cols [6];
  logic [NCH-1:0][AW-1:0] csum [5];

  always_ff @(posedge clk) begin
    if (rst) begin
      e2 <= 1'b0;
    end else begin
      e2 <= e1;
    end
    last2 <= last1;
    msk2  <= msk1;
    cm2   <= cm1;
  end

  assign cols[5] = ncol;

  for (genvar j = 0; j < 5; j++) begin : g_cell
    gbw_cell #(.COL(j), .NCH(NCH), .FRAC(COEF_FRAC_BITS)) u_cell (
      .clk     (clk),
      .shift   (v1),
      .col_in  (cols[j+1]),
      .col_out (cols[j]),
      .cmask   (cm2[j]),
      .ctl     (msk2),
      .sum     (csum[j])
    );
  end

  // stage 3: add columns, truncate, saturate
  logic       e3, last3;
  logic [2:0][7:0] sat;
  gbw_pkg::gbw_word_t qin;

  always_ff @(posedge clk) begin
    if (rst) begin
      e3 <= 1'b0;
    end else begin
      e3 <= e2;
    end
    last3 <= last2;
  end

  for (genvar c = 0; c < 3; c++) begin : g_sat
    if (c < NCH) begin : g_on
      logic [TW-1:0] tot;
      logic [TW-1:0] s;
      always_comb begin
        tot = '0;
        for (int j = 0; j < 5; j++) begin
          tot = tot + TW'(csum[j][c]);
        end
        s = tot >> COEF_FRAC_BITS;
        sat[c] = (s > TW'(255)) ? 8'd255 : s[7:0];
      end
    end else begin : g_off
      assign sat[c] = 8'd0;
    end
  end

  assign qin = '{ch2: sat[2], ch1: sat[1], ch0: sat[0], last: last3};

  // output queue
  gbw_pkg::gbw_word_t q [QDEPTH];
  logic [QPW-1:0] wp, rp;
  logic [QPW:0]   cnt;
  logic           pop;
  logic [QPW+1:0] pending;

  assign pop     = out_valid && !out_stall;
  assign pending = (QPW+2)'(cnt) + (QPW+2)'(e1) + (QPW+2)'(e2) + (QPW+2)'(e3);
  assign in_stall = pending >= (QPW+2)'(QDEPTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (e3) begin
        wp <= wp + QPW'(1);
      end
      if (pop) begin
        rp <= rp + QPW'(1);
      end
      cnt <= cnt + (QPW+1)'(e3) - (QPW+1)'(pop);
    end
    if (e3) begin
      q[wp] <= qin;
    end
  end

  assign out_valid  = cnt != '0;
  assign out_ch0    = q[rp].ch0;
  assign out_ch1    = q[rp].ch1;
  assign out_ch2    = q[rp].ch2;
  assign frame_last = q[rp].last;

endmodule

>>> design/gbw_checker.sv
// Port-level checks for the window filter and their binding to the top level.
module gbw_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_ch0,
  input logic [7:0] out_ch1,
  input logic [7:0] out_ch2,
  input logic       frame_last
);

  // reset empties the queue and opens the input
  a_reset_clear: assert property (@(posedge clk) rst |=> !out_valid && !in_stall)
    else $error("output or input stall active after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("stalled output word dropped");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(out_ch0) && $stable(out_ch1) && $stable(out_ch2)
      && $stable(frame_last))
    else $error("stalled output word changed");

  // the input stall is driven from queue occupancy plus results still in flight
  a_stall_src: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall || $past(in_valid && !in_stall))
    else $error("input stalled with empty queue and no recent input");

endmodule

bind gaussian_box_window_filter gbw_checker u_gbw_checker (.*);

>>> verif/tb_gaussian_box_window_filter.sv
// Testbench for the Gaussian 5x5 / box 3x3 window filter: raster frames against a local predictor.
`timescale 1ns / 1ps

module tb_gaussian_box_window_filter;

  localparam int LINE_MAX = 2048;
  localparam int FLUSH_CYCLES = 20;

  typedef struct packed {
    logic [7:0] ch0;
    logic [7:0] ch1;
    logic [7:0] ch2;
    logic       last;
  } filtered_px_t;

  logic        clk;
  logic        rst;
  logic        cfg_write;
  logic [1:0]  cfg_index;
  logic [12:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic        req_type;
  logic [7:0]  pixel_ch0;
  logic [7:0]  pixel_ch1;
  logic [7:0]  pixel_ch2;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_ch0;
  logic [7:0]  out_ch1;
  logic [7:0]  out_ch2;
  logic        frame_last;

  gaussian_box_window_filter i_dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .req_type(req_type),
    .pixel_ch0(pixel_ch0), .pixel_ch1(pixel_ch1), .pixel_ch2(pixel_ch2),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_ch0(out_ch0), .out_ch1(out_ch1), .out_ch2(out_ch2), .frame_last(frame_last)
  );

  // predictor state
  logic              mode_reg;
  logic [11:0]       width_reg;
  logic [12:0]       height_reg;
  logic [23:0]       line_rows [4*LINE_MAX];
  logic [23:0]       win [25];
  int unsigned       in_col, in_row, out_col, out_row;
  longint unsigned   gauss_q [25];
  longint unsigned   box_q;

  filtered_px_t      pending_px [$];
  int                errors;
  int                sent_words;
  bit                tx_fast;
  bit                rx_fast;
  int                hold_cycles;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #100ms;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic longint unsigned to_q16(input longint unsigned num);
    return ((num << 16) + 64'd500000) / 64'd1000000;
  endfunction

  function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned hi);
    return v < gbw_pkg::MIN_DIM ? gbw_pkg::MIN_DIM : (v > hi ? hi : v);
  endfunction

  function automatic logic [7:0] sat8(input longint unsigned acc);
    longint unsigned s;
    s = acc >> 16;
    return s > 255 ? 8'd255 : s[7:0];
  endfunction

  task automatic report(input string what);
    errors++;
    $display("mismatch: %s", what);
  endtask

  // advance the predictor by one accepted word
  task automatic predict_word(input logic drain, input logic [7:0] b, g, r);
    int unsigned w, h, rad, ctr;
    logic [23:0] pix, v;
    logic emit, boxm, last;
    int rr, cc;
    longint unsigned a0, a1, a2, wt;
    filtered_px_t e;
    w = clamp_dim(width_reg, LINE_MAX);
    h = clamp_dim(height_reg, gbw_pkg::MAX_HEIGHT);
    boxm = mode_reg;
    rad = boxm ? 1 : 2;
    if (drain && in_row == 0 && in_col == 0) return;
    pix = (!drain && in_row < h) ? {r, g, b} : 24'd0;
    for (int i = 0; i < 5; i++)
      for (int j = 0; j < 4; j++) win[i*5+j] = win[i*5+j+1];
    if (in_col < LINE_MAX) begin
      for (int i = 0; i < 4; i++) win[i*5+4] = line_rows[((in_row + i) & 3) * LINE_MAX + in_col];
      line_rows[(in_row & 3) * LINE_MAX + in_col] = pix;
    end else begin
      for (int i = 0; i < 4; i++) win[i*5+4] = 24'd0;
    end
    win[24] = pix;
    emit = in_row > rad || (in_row == rad && in_col >= rad);
    if (in_col + 1 >= w) begin
      in_col = 0;
      in_row = (in_row + 1) & 13'h1FFF;
    end else begin
      in_col++;
    end
    if (!emit) return;
    ctr = boxm ? 3 : 2;
    a0 = 0; a1 = 0; a2 = 0;
    for (int i = 0; i < 5; i++) begin
      for (int j = 0; j < 5; j++) begin
        rr = int'(out_row) + i - int'(ctr);
        cc = int'(out_col) + j - int'(ctr);
        if (boxm && (i < 2 || j < 2)) continue;
        if (rr < 0 || cc < 0 || rr >= int'(h) || cc >= int'(w)) continue;
        wt = boxm ? box_q : gauss_q[i*5+j];
        v = win[i*5+j];
        a0 += wt * v[7:0];
        a1 += wt * v[15:8];
        a2 += wt * v[23:16];
      end
    end
    last = out_row + 1 >= h && out_col + 1 >= w;
    e.ch0 = sat8(a0);
    e.ch1 = sat8(a1);
    e.ch2 = sat8(a2);
    e.last = last;
    pending_px.push_back(e);
    if (last) begin
      in_row = 0; in_col = 0; out_row = 0; out_col = 0;
    end else if (out_col + 1 >= w) begin
      out_col = 0;
      out_row = (out_row + 1) & 12'hFFF;
    end else begin
      out_col++;
    end
  endtask

  task automatic send_word(input logic drain, input logic [7:0] b, g, r);
    int gap;
    gap = tx_fast ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      @(negedge clk) in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid = 1'b1;
    req_type = drain;
    pixel_ch0 = b;
    pixel_ch1 = g;
    pixel_ch2 = r;
    do @(posedge clk); while (in_stall);
    predict_word(drain, b, g, r);
    sent_words++;
  endtask

  task automatic send_random(input int drain_pct);
    send_word($urandom_range(0, 99) < drain_pct, 8'($urandom_range(0, 255)),
              8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
  endtask

  task automatic wait_idle();
    @(negedge clk) in_valid = 1'b0;
    while (pending_px.size() != 0) @(posedge clk);
    repeat (FLUSH_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [12:0] val);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk) cfg_write = 1'b0;
    case (idx)
      gbw_pkg::REG_MODE:   mode_reg = val[0];
      gbw_pkg::REG_WIDTH:  width_reg = val[11:0];
      gbw_pkg::REG_HEIGHT: height_reg = val;
      default: ;
    endcase
  endtask

  task automatic setup(input logic m, input logic [12:0] w, input logic [12:0] h);
    wait_idle();
    write_reg(gbw_pkg::REG_MODE, {12'd0, m});
    write_reg(gbw_pkg::REG_WIDTH, w);
    write_reg(gbw_pkg::REG_HEIGHT, h);
  endtask

  // drain ticks (with some surplus pixels) until the frame closes
  task automatic finish_frame(input int surplus_pct);
    while (in_row != 0 || in_col != 0) send_random(100 - surplus_pct);
  endtask

  task automatic send_frame(input int early_pct, input int surplus_pct);
    int n;
    n = clamp_dim(width_reg, LINE_MAX) * clamp_dim(height_reg, gbw_pkg::MAX_HEIGHT);
    for (int k = 0; k < n; k++) send_random(early_pct);
    finish_frame(surplus_pct);
  endtask

  task automatic test_directed_gauss();
    setup(1'b0, 13'd5, 13'd5);
    send_word(1'b1, 8'd0, 8'd0, 8'd0);     // idle drain tick
    for (int k = 0; k < 25; k++) begin
      if (k == 7) send_word(1'b1, 8'hFF, 8'hFF, 8'hFF);   // early drain
      else send_word(1'b0, 8'hFF, (k % 2) ? 8'hFF : 8'h00, 8'h00);
    end
    send_word(1'b0, 8'hAA, 8'h55, 8'hFF);  // surplus pixel
    finish_frame(0);
  endtask

  task automatic test_directed_box();
    setup(1'b1, 13'd5, 13'd5);
    for (int k = 0; k < 25; k++) send_word(1'b0, 8'hFF, 8'hFF, (k % 3 == 0) ? 8'hFF : 8'h01);
    finish_frame(30);
  endtask

  task automatic test_random_frames();
    int start;
    start = sent_words;
    while (sent_words - start < 1100) begin
      tx_fast = ($urandom_range(0, 3) == 0);
      rx_fast = ($urandom_range(0, 3) == 0);
      setup(1'($urandom_range(0, 1)),
            13'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 4) : $urandom_range(5, 14)),
            13'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 4) : $urandom_range(5, 9)));
      send_frame($urandom_range(0, 1) ? 0 : 5, 20);
    end
    tx_fast = 0;
    rx_fast = 0;
  endtask

  task automatic test_backpressure();
    setup(1'b0, 13'd16, 13'd6);
    tx_fast = 1;
    hold_cycles = 400;
    send_frame(0, 0);
    tx_fast = 0;
  endtask

  task automatic test_pause_mode_switch();
    setup(1'b1, 13'd9, 13'd7);
    for (int k = 0; k < 30; k++) send_random(0);
    // sender pauses until everything is out, then switch kernel mid-frame
    wait_idle();
    write_reg(gbw_pkg::REG_MODE, 13'd0);
    for (int k = 30; k < 63; k++) send_random(0);
    finish_frame(10);
  endtask

  task automatic test_extreme_dims();
    tx_fast = 1;
    rx_fast = 1;
    setup(1'b1, 13'h0FFF, 13'h1FFF);   // both dimensions saturate
    for (int k = 0; k < 120; k++) send_random(1);
    // shrink the frame mid-row; counters wrap at the new width
    setup(1'b0, 13'd5, 13'd5);
    finish_frame(10);
    tx_fast = 0;
    rx_fast = 0;
  endtask

  // receiver: random stall per word, plus an occasional long hold-off
  initial begin
    int n;
    out_stall = 1'b1;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_cycles > 0) begin
        @(negedge clk) out_stall = 1'b1;
        repeat (hold_cycles) @(negedge clk);
        hold_cycles = 0;
      end
      n = rx_fast ? 0 : $urandom_range(0, 12);
      if (n > 0) begin
        @(negedge clk) out_stall = 1'b1;
        repeat (n - 1) @(negedge clk);
      end
      @(negedge clk) out_stall = 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // result checker
  initial begin
    filtered_px_t e;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        if (pending_px.size() == 0) begin
          report("result with nothing expected");
        end else begin
          e = pending_px.pop_front();
          if (out_ch0 !== e.ch0) report($sformatf("ch0 got %0d want %0d", out_ch0, e.ch0));
          if (out_ch1 !== e.ch1) report($sformatf("ch1 got %0d want %0d", out_ch1, e.ch1));
          if (out_ch2 !== e.ch2) report($sformatf("ch2 got %0d want %0d", out_ch2, e.ch2));
          if (frame_last !== e.last)
            report($sformatf("frame_last got %0b want %0b", frame_last, e.last));
        end
      end
    end
  end

  initial begin
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = gbw_pkg::REG_MODE;
    cfg_data = '0;
    in_valid = 1'b0;
    req_type = 1'b0;
    pixel_ch0 = '0;
    pixel_ch1 = '0;
    pixel_ch2 = '0;
    errors = 0;
    sent_words = 0;
    tx_fast = 0;
    rx_fast = 0;
    hold_cycles = 0;
    mode_reg = 1'b0;
    width_reg = 12'd512;
    height_reg = 13'd512;
    in_col = 0; in_row = 0; out_col = 0; out_row = 0;
    foreach (line_rows[k]) line_rows[k] = '0;
    foreach (win[k]) win[k] = '0;
    foreach (gauss_q[k]) gauss_q[k] = to_q16(gbw_pkg::GAUSS_NUM[k]);
    box_q = to_q16(gbw_pkg::BOX_NUM);
    repeat (5) @(posedge clk);
    @(negedge clk) rst = 1'b0;

    test_directed_gauss();
    test_directed_box();
    test_backpressure();
    test_pause_mode_switch();
    test_random_frames();
    test_extreme_dims();

    wait_idle();
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
